FILE: rtl/core/frb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frb_pkg
// Types and constants shared by the frame ring buffer modules.
// ----------------------------------------------------------------------------
package frb_pkg;

   localparam logic [1:0] OPC_WRITE = 2'd0;
   localparam logic [1:0] OPC_READ  = 2'd1;
   localparam logic [1:0] OPC_CLEAR = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_FRAME_LEN   = 1'b0;
   localparam logic [0:0] REG_RING_FRAMES = 1'b1;

   localparam logic [6:0] FRAME_LEN_RESET   = 7'd64;
   localparam logic [4:0] RING_FRAMES_RESET = 5'd16;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   typedef logic [4:0] held_type;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] sample_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               last_of_frame;
      logic               status;
      held_type           frames_held;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  sample;
   } cmd_type;

   typedef struct packed {
      logic       clear;
      logic [6:0] len;
      logic [4:0] ring;
   } ctrl_type;

endpackage
`default_nettype wire

FILE: rtl/core/frb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module frb_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  wire logic [Width-1:0]                    wr_data,
   input  wire logic                                rd_en,
   input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic      [Width-1:0]                    rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/frb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frb_front
// Accepts items, decodes the opcode and queues commands for the back end; items with an unknown opcode are dropped.
// ----------------------------------------------------------------------------
module frb_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire frb_pkg::req_type req_data,
   output logic                 full,
   output logic                 cmd_valid,
   input  wire logic            cmd_pop,
   output frb_pkg::cmd_type     cmd_data
);

   localparam int PtrW = (frb_pkg::CMD_DEPTH > 1) ? $clog2(frb_pkg::CMD_DEPTH) : 1;
   localparam int CntW = $clog2(frb_pkg::CMD_DEPTH + 1);

   frb_pkg::cmd_type q_ff [frb_pkg::CMD_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   frb_pkg::cmd_type dec_cmd;
   logic             dec_keep;
   logic             enq;
   logic             deq;

   always_comb begin
      dec_cmd.sample = req_data.sample_in;
      dec_cmd.kind   = frb_pkg::CMD_WRITE;
      dec_keep       = 1'b1;
      case (req_data.opcode)
         frb_pkg::OPC_WRITE: dec_cmd.kind = frb_pkg::CMD_WRITE;
         frb_pkg::OPC_READ:  dec_cmd.kind = frb_pkg::CMD_READ;
         frb_pkg::OPC_CLEAR: dec_cmd.kind = frb_pkg::CMD_CLEAR;
         default:            dec_keep     = 1'b0;
      endcase
   end

   assign full      = (count_ff == CntW'(frb_pkg::CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign enq       = push && !full && dec_keep;
   assign deq       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(frb_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(frb_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/frb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frb_back
// Executes queued commands against the frame store and queues the results.
// ----------------------------------------------------------------------------
module frb_back #(
   parameter int MaxFrame = 64,
   parameter int MaxSlots = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire frb_pkg::ctrl_type ctrl,
   input  wire logic             cmd_valid,
   input  wire frb_pkg::cmd_type  cmd_data,
   output logic                  cmd_pop,
   input  wire logic             pop,
   output logic                  empty,
   output frb_pkg::rsp_type      rsp_data
);

   localparam int SlotW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
   localparam int OffW  = (MaxFrame > 1) ? $clog2(MaxFrame) : 1;
   localparam int CntW  = $clog2(MaxSlots + 1);
   localparam int LenW  = $clog2(MaxFrame + 1);
   localparam int Depth = MaxFrame * MaxSlots;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam logic [AddrW:0] Stride = (AddrW + 1)'(MaxFrame);
   localparam int OqPtrW = $clog2(frb_pkg::RSP_DEPTH);
   localparam int OqCntW = $clog2(frb_pkg::RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [SlotW-1:0] wslot_ff, wslot_in;
   logic [OffW-1:0]  woff_ff, woff_in;
   logic [CntW-1:0]  filled_ff, filled_in;
   logic [SlotW-1:0] pos_ff, pos_in;
   logic [OffW-1:0]  k_ff, k_in;

   logic [CntW-1:0]  ring_n;
   logic [LenW-1:0]  len_n;

   logic             drop;
   logic [CntW-1:0]  f1;
   logic [LenW-1:0]  woff_inc;
   logic [CntW-1:0]  slot_inc;
   logic [CntW:0]    pos_sum;
   logic [CntW:0]    pos_wrap;

   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   logic             rd_en;
   logic [AddrW-1:0] rd_addr;
   logic [15:0]      ram_rd_data;

   logic              can_issue;
   logic              issue;
   logic              issue_ram;
   logic              issue_last;
   logic              issue_status;
   frb_pkg::held_type issue_held;

   logic              s1_valid_ff;
   logic              s1_ram_ff;
   logic              s1_last_ff;
   logic              s1_status_ff;
   frb_pkg::held_type s1_held_ff;

   frb_pkg::rsp_type  oq_ff [frb_pkg::RSP_DEPTH];
   frb_pkg::rsp_type  oq_wdata;
   logic [OqPtrW-1:0] oq_wp_ff, oq_rp_ff;
   logic [OqCntW-1:0] oq_cnt_ff, oq_cnt_in;
   logic              oq_push;
   logic              oq_pop;

   assign ring_n = CntW'(ctrl.ring);
   assign len_n  = LenW'(ctrl.len);

   assign drop     = (woff_ff == '0) && (filled_ff == ring_n);
   assign f1       = filled_ff - CntW'(drop);
   assign woff_inc = LenW'(woff_ff) + 1'b1;
   assign slot_inc = CntW'(wslot_ff) + 1'b1;
   assign pos_sum  = (CntW + 1)'(wslot_ff) + (CntW + 1)'(ring_n) - (CntW + 1)'(filled_ff);
   assign pos_wrap = (pos_sum >= (CntW + 1)'(ring_n)) ? pos_sum - (CntW + 1)'(ring_n) : pos_sum;

   assign wr_addr = AddrW'({1'b0, AddrW'(wslot_ff)} * Stride + (AddrW + 1)'(woff_ff));
   assign rd_addr = AddrW'({1'b0, AddrW'(pos_ff)} * Stride + (AddrW + 1)'(k_ff));

   assign can_issue = ((OqCntW + 1)'(oq_cnt_ff) + (OqCntW + 1)'(s1_valid_ff))
                      < (OqCntW + 1)'(frb_pkg::RSP_DEPTH - 1);

   always_comb begin
      state_in     = state_ff;
      wslot_in     = wslot_ff;
      woff_in      = woff_ff;
      filled_in    = filled_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      issue        = 1'b0;
      issue_ram    = 1'b0;
      issue_last   = 1'b0;
      issue_status = 1'b0;
      issue_held   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_data.kind)
                  frb_pkg::CMD_WRITE: begin
                     cmd_pop = 1'b1;
                     wr_en   = 1'b1;
                     if (woff_inc >= len_n) begin
                        woff_in   = '0;
                        wslot_in  = (slot_inc >= ring_n) ? '0 : SlotW'(slot_inc);
                        filled_in = (f1 < ring_n) ? f1 + 1'b1 : f1;
                     end else begin
                        woff_in   = OffW'(woff_inc);
                        filled_in = f1;
                     end
                  end
                  frb_pkg::CMD_READ: begin
                     if (filled_ff == '0) begin
                        if (can_issue) begin
                           cmd_pop      = 1'b1;
                           issue        = 1'b1;
                           issue_last   = 1'b1;
                           issue_status = 1'b1;
                        end
                     end else begin
                        cmd_pop   = 1'b1;
                        pos_in    = SlotW'(pos_wrap);
                        filled_in = filled_ff - 1'b1;
                        k_in      = '0;
                        state_in  = ST_READ;
                     end
                  end
                  frb_pkg::CMD_CLEAR: begin
                     cmd_pop   = 1'b1;
                     wslot_in  = '0;
                     woff_in   = '0;
                     filled_in = '0;
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            if (can_issue) begin
               issue      = 1'b1;
               issue_ram  = 1'b1;
               rd_en      = 1'b1;
               issue_last = ((LenW'(k_ff) + 1'b1) == len_n);
               issue_held = frb_pkg::held_type'(filled_ff);
               if (issue_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (ctrl.clear) begin
         wslot_in  = '0;
         woff_in   = '0;
         filled_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wslot_ff    <= '0;
         woff_ff     <= '0;
         filled_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wslot_ff    <= wslot_in;
         woff_ff     <= woff_in;
         filled_ff   <= filled_in;
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      k_ff         <= k_in;
      s1_ram_ff    <= issue_ram;
      s1_last_ff   <= issue_last;
      s1_status_ff <= issue_status;
      s1_held_ff   <= issue_held;
   end

   frb_ram #(
      .Width(16),
      .Depth(Depth)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(cmd_data.sample),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   // result queue
   assign oq_push = s1_valid_ff;
   assign oq_pop  = pop && !empty;
   assign empty   = (oq_cnt_ff == '0);
   assign rsp_data = oq_ff[oq_rp_ff];

   always_comb begin
      oq_wdata.sample_out    = s1_ram_ff ? ram_rd_data : 16'sd0;
      oq_wdata.last_of_frame = s1_last_ff;
      oq_wdata.status        = s1_status_ff;
      oq_wdata.frames_held   = s1_held_ff;
   end

   always_comb begin
      oq_cnt_in = oq_cnt_ff;
      if (oq_push && !oq_pop) begin
         oq_cnt_in = oq_cnt_ff + 1'b1;
      end else if (oq_pop && !oq_push) begin
         oq_cnt_in = oq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wp_ff  <= '0;
         oq_rp_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_cnt_ff <= oq_cnt_in;
         if (oq_push) begin
            oq_wp_ff <= oq_wp_ff + 1'b1;
         end
         if (oq_pop) begin
            oq_rp_ff <= oq_rp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wp_ff] <= oq_wdata;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/frame_ring_buffer_overwrite_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_ring_buffer_overwrite_core
// Ring of fixed-length audio frames that overwrites the oldest frame.
// ----------------------------------------------------------------------------
// Items are taken into a two-entry command queue and executed in order by the
// back end. A read item first computes the oldest slot and then reads one
// sample per cycle, paced by the single read port of the frame store and by
// room in the four-entry result queue; a read of an empty ring also waits
// for room there. The store is not cleared after reset, so the block is
// ready at once. Writing either register empties the ring; write registers
// only while idle.
module frame_ring_buffer_overwrite_core #(
   parameter int MaxFrame = 64,
   parameter int MaxSlots = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   input  wire frb_pkg::req_type                  req_data,
   output logic                                   full,
   output logic                                   empty,
   input  wire logic                              pop,
   output frb_pkg::rsp_type                       rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [frb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [31:0]                       pwdata,
   output logic      [31:0]                       prdata,
   output logic                                   pready
);

   logic [6:0]        frame_len_ff, frame_len_in;
   logic [4:0]        ring_frames_ff, ring_frames_in;
   logic              csr_wr;
   logic              csr_clear;
   frb_pkg::ctrl_type ctrl;
   logic              cmd_valid;
   logic              cmd_pop;
   frb_pkg::cmd_type  cmd_data;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      frame_len_in   = frame_len_ff;
      ring_frames_in = ring_frames_ff;
      csr_clear      = 1'b0;
      prdata         = '0;
      case (paddr[2])
         frb_pkg::REG_FRAME_LEN: begin
            prdata = {25'd0, frame_len_ff};
            if (csr_wr) begin
               frame_len_in = pwdata[6:0];
               csr_clear    = 1'b1;
            end
         end
         frb_pkg::REG_RING_FRAMES: begin
            prdata = {27'd0, ring_frames_ff};
            if (csr_wr) begin
               ring_frames_in = pwdata[4:0];
               csr_clear      = 1'b1;
            end
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff   <= frb_pkg::FRAME_LEN_RESET;
         ring_frames_ff <= frb_pkg::RING_FRAMES_RESET;
      end else begin
         frame_len_ff   <= frame_len_in;
         ring_frames_ff <= ring_frames_in;
      end
   end

   always_comb begin
      ctrl.clear = csr_clear;
      if (frame_len_ff == '0) begin
         ctrl.len = 7'd1;
      end else if (32'(frame_len_ff) > MaxFrame) begin
         ctrl.len = 7'(MaxFrame);
      end else begin
         ctrl.len = frame_len_ff;
      end
      if (ring_frames_ff == '0) begin
         ctrl.ring = 5'd1;
      end else if (32'(ring_frames_ff) > MaxSlots) begin
         ctrl.ring = 5'(MaxSlots);
      end else begin
         ctrl.ring = ring_frames_ff;
      end
   end

   frb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .cmd_valid(cmd_valid),
      .cmd_pop  (cmd_pop),
      .cmd_data (cmd_data)
   );

   frb_back #(
      .MaxFrame(MaxFrame),
      .MaxSlots(MaxSlots)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cmd_valid(cmd_valid),
      .cmd_data (cmd_data),
      .cmd_pop  (cmd_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

FILE: rtl/core/frb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frb_checker
// Port-level checks for the frame ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module frb_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             push,
   input wire logic             full,
   input wire logic             pop,
   input wire logic             empty,
   input wire frb_pkg::rsp_type rsp_data
);

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result queue not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   a_status_item: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status) |->
         (rsp_data.last_of_frame && rsp_data.frames_held == '0 && rsp_data.sample_out == '0))
      else $error("malformed empty-ring item");

   a_mid_frame_ok: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.last_of_frame) |-> !rsp_data.status)
      else $error("status set inside a frame");

   a_full_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push))
      else $error("input side went full without a push");

endmodule

bind frame_ring_buffer_overwrite_core frb_checker u_frb_checker (.*);
`default_nettype wire
